### src/wbj_pkg.sv
// Package for the weighted block jackknife: payload structs, control structs
// between the top level and the evaluation unit, and fixed constants.
// No dependencies.
package wbj_pkg;

    typedef struct packed {
        logic signed [31:0] block_estimate;
        logic               estimate_ok;
        logic [31:0]        block_weight;
        logic               last;
    } t_item;

    typedef struct packed {
        logic signed [31:0] jack_estimate;
        logic               estimate_valid;
        logic [30:0]        std_error;
        logic               error_valid;
        logic [5:0]         kept_blocks;
        logic               overflowed;
    } t_result;

    typedef struct packed {
        logic start;
        logic take;
    } t_eval_cmd;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_eval_sts;

    localparam int MUL_AW = 128;
    localparam int MUL_BW = 64;
    localparam int DIV_NW = 128;
    localparam int DIV_DW = 64;

    localparam logic [2:0]  ADDR_FULL_ESTIMATE = 3'h0;
    localparam logic [63:0] TAU_SAT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;
    localparam logic [30:0] SE_SAT    = 31'h7FFF_FFFF;

endpackage

### src/wbj_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module wbj_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/wbj_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle,
// finishing early when the remaining multiplier bits are zero. Uses wbj_pkg.
module wbj_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wbj_pkg::MUL_AW-1:0] i_a,
    input  logic [wbj_pkg::MUL_BW-1:0] i_b,
    output logic                       o_done,
    output logic [wbj_pkg::MUL_AW-1:0] o_prod
);

    logic                       r_busy;
    logic                       r_done;
    logic [wbj_pkg::MUL_AW-1:0] r_a;
    logic [wbj_pkg::MUL_BW-1:0] r_b;
    logic [wbj_pkg::MUL_AW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_p <= r_p + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

### src/wbj_div.sv
// Restoring divider, one quotient bit per cycle over the full numerator.
// Truncating unsigned quotient. Uses wbj_pkg.
module wbj_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wbj_pkg::DIV_NW-1:0] i_num,
    input  logic [wbj_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [wbj_pkg::DIV_NW-1:0] o_quot
);

    localparam int CW = $clog2(wbj_pkg::DIV_NW);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [wbj_pkg::DIV_DW-1:0] r_rem;
    logic [wbj_pkg::DIV_DW-1:0] r_den;
    logic [wbj_pkg::DIV_NW-1:0] r_q;
    logic [wbj_pkg::DIV_DW:0]   rem_sh;
    logic [wbj_pkg::DIV_DW:0]   diff;
    logic                       ge;

    always_comb begin
        rem_sh = {r_rem, r_q[wbj_pkg::DIV_NW-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
            end else if (r_busy) begin
                r_rem <= ge ? diff[wbj_pkg::DIV_DW-1:0] : rem_sh[wbj_pkg::DIV_DW-1:0];
                r_q   <= {r_q[wbj_pkg::DIV_NW-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(wbj_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### src/wbj_eval.sv
// Final pass over the block store: weighted mean, bias-corrected estimate,
// variance terms and square root. Uses wbj_pkg, wbj_mul and wbj_div.
module wbj_eval #(
    parameter int MAX_BLOCKS = 32,
    localparam int IDX_W = $clog2(MAX_BLOCKS),
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
    localparam int WT_W  = 32 + CNT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbj_pkg::t_eval_cmd i_cmd,
    output wbj_pkg::t_eval_sts o_sts,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [WT_W-1:0]    i_wtotal,
    input  logic [31:0]        i_full_est,
    input  logic               i_overflow,
    output logic [IDX_W-1:0]   o_raddr,
    input  logic [63:0]        i_rdata,
    output wbj_pkg::t_result   o_res
);

    localparam int ACC_W = 64 + CNT_W;
    localparam int MS_W  = 32 + CNT_W;

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_P1_RD  = 20'h00002,
        ST_P1_GO  = 20'h00004,
        ST_P1_MUL = 20'h00008,
        ST_MSTART = 20'h00010,
        ST_MEAN   = 20'h00020,
        ST_JACK   = 20'h00040,
        ST_P2_RD  = 20'h00080,
        ST_P2_GO  = 20'h00100,
        ST_P2_AML = 20'h00200,
        ST_P2_ADV = 20'h00400,
        ST_P2_ABS = 20'h00800,
        ST_P2_SQ  = 20'h01000,
        ST_P2_TML = 20'h02000,
        ST_P2_TDV = 20'h04000,
        ST_VSTART = 20'h08000,
        ST_VAR    = 20'h10000,
        ST_SQRT   = 20'h20000,
        ST_FIN    = 20'h40000,
        ST_DONE   = 20'h80000
    } t_state;

    t_state                     r_state;
    logic [CNT_W-1:0]           r_k;
    logic [CNT_W-1:0]           r_g;
    logic [WT_W-1:0]            r_yn;
    logic [31:0]                r_f;
    logic                       r_ovf;
    logic [31:0]                r_m;
    logic [31:0]                r_w;
    logic                       r_dneg;
    logic [ACC_W-1:0]           r_acc;
    logic                       r_accneg;
    logic [MS_W-1:0]            r_msum;
    logic [63:0]                r_wmean;
    logic [63:0]                r_j;
    logic [127:0]               r_tau;
    logic [127:0]               r_vsum;
    logic [63:0]                r_sv;
    logic [63:0]                r_sres;
    logic [63:0]                r_sbit;
    logic                       r_var_big;
    logic                       r_var_nz;
    wbj_pkg::t_result           r_res;
    logic                       r_res_valid;

    logic                       r_mul_start;
    logic [wbj_pkg::MUL_AW-1:0] r_mul_a;
    logic [wbj_pkg::MUL_BW-1:0] r_mul_b;
    logic                       mul_done;
    logic [wbj_pkg::MUL_AW-1:0] mul_prod;
    logic                       r_div_start;
    logic [wbj_pkg::DIV_NW-1:0] r_div_num;
    logic [wbj_pkg::DIV_DW-1:0] r_div_den;
    logic                       div_done;
    logic [wbj_pkg::DIV_NW-1:0] div_q;

    logic [31:0]          rd_m;
    logic [31:0]          rd_w;
    logic [32:0]          rd_mabs;
    logic [32:0]          rd_d;
    logic [32:0]          rd_dabs;
    logic [ACC_W-1:0]     acc_abs;
    logic [ACC_W-1:0]     prod_ext;
    logic [CNT_W-1:0]     n_k;
    logic signed [CNT_W+32:0] gf;
    logic [63:0]          n_j;
    logic [63:0]          mj;
    logic [127:0]         n_tau;
    logic [127:0]         tabs;
    logic [63:0]          tmag;
    logic [128:0]         vs;
    logic [63:0]          trial;
    logic signed [47:0]   jq;
    logic [31:0]          jsat;

    always_comb begin
        rd_m     = i_rdata[63:32];
        rd_w     = i_rdata[31:0];
        rd_mabs  = rd_m[31] ? (33'd0 - {rd_m[31], rd_m}) : {1'b0, rd_m};
        rd_d     = {r_f[31], r_f} - {rd_m[31], rd_m};
        rd_dabs  = rd_d[32] ? (33'd0 - rd_d) : rd_d;
        acc_abs  = r_acc[ACC_W-1] ? ('0 - r_acc) : r_acc;
        prod_ext = {{CNT_W{1'b0}}, mul_prod[63:0]};
        n_k      = r_k + CNT_W'(1);
        gf       = $signed({1'b0, r_g}) * $signed(r_f);
        n_j      = ({{(64-CNT_W-33){gf[CNT_W+32]}}, gf} << 16)
                 - ({{(64-MS_W){r_msum[MS_W-1]}}, r_msum} << 16) + r_wmean;
        mj       = ({{32{r_m[31]}}, r_m} << 16) - r_j;
        n_tau    = (r_dneg ? (128'd0 - div_q) : div_q) + {{64{mj[63]}}, mj};
        tabs     = r_tau[127] ? (128'd0 - r_tau) : r_tau;
        tmag     = (tabs[127:63] != '0) ? wbj_pkg::TAU_SAT : tabs[63:0];
        vs       = {1'b0, r_vsum} + {1'b0, div_q};
        trial    = r_sres + r_sbit;
        jq       = $signed(r_j[63:16]);
        if (r_j[63] && (r_j[15:0] != '0)) begin
            jq = jq + 48'sd1;
        end
        if (jq > $signed(48'h0000_7FFF_FFFF)) begin
            jsat = 32'h7FFF_FFFF;
        end else if (jq < $signed(48'hFFFF_8000_0000)) begin
            jsat = 32'h8000_0000;
        end else begin
            jsat = jq[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_res_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_g    <= i_count;
                        r_yn   <= i_wtotal;
                        r_f    <= i_full_est;
                        r_ovf  <= i_overflow;
                        r_acc  <= '0;
                        r_msum <= '0;
                        r_vsum <= '0;
                        r_k    <= '0;
                        if (i_count < CNT_W'(2)) begin
                            r_res.jack_estimate  <= '0;
                            r_res.estimate_valid <= 1'b0;
                            r_res.std_error      <= '0;
                            r_res.error_valid    <= 1'b0;
                            r_res.kept_blocks    <= 6'(i_count);
                            r_res.overflowed     <= i_overflow;
                            r_res_valid          <= 1'b1;
                            r_state              <= ST_DONE;
                        end else begin
                            r_state <= ST_P1_RD;
                        end
                    end
                end
                ST_P1_RD: begin
                    r_state <= ST_P1_GO;
                end
                ST_P1_GO: begin
                    r_m         <= rd_m;
                    r_mul_a     <= wbj_pkg::MUL_AW'(rd_mabs);
                    r_mul_b     <= wbj_pkg::MUL_BW'(rd_w);
                    r_mul_start <= 1'b1;
                    r_state     <= ST_P1_MUL;
                end
                ST_P1_MUL: begin
                    if (mul_done) begin
                        r_acc  <= r_m[31] ? (r_acc - prod_ext) : (r_acc + prod_ext);
                        r_msum <= r_msum + {{CNT_W{r_m[31]}}, r_m};
                        r_k    <= n_k;
                        r_state <= (n_k == r_g) ? ST_MSTART : ST_P1_RD;
                    end
                end
                ST_MSTART: begin
                    r_accneg    <= r_acc[ACC_W-1];
                    r_div_num   <= wbj_pkg::DIV_NW'(acc_abs) << 16;
                    r_div_den   <= wbj_pkg::DIV_DW'(r_yn);
                    r_div_start <= 1'b1;
                    r_state     <= ST_MEAN;
                end
                ST_MEAN: begin
                    if (div_done) begin
                        r_wmean <= r_accneg ? (64'd0 - div_q[63:0]) : div_q[63:0];
                        r_state <= ST_JACK;
                    end
                end
                ST_JACK: begin
                    r_j     <= n_j;
                    r_k     <= '0;
                    r_state <= ST_P2_RD;
                end
                ST_P2_RD: begin
                    r_state <= ST_P2_GO;
                end
                ST_P2_GO: begin
                    r_m         <= rd_m;
                    r_w         <= rd_w;
                    r_dneg      <= rd_d[32];
                    r_mul_a     <= wbj_pkg::MUL_AW'(r_yn);
                    r_mul_b     <= wbj_pkg::MUL_BW'(rd_dabs);
                    r_mul_start <= 1'b1;
                    r_state     <= ST_P2_AML;
                end
                ST_P2_AML: begin
                    if (mul_done) begin
                        r_div_num   <= mul_prod << 16;
                        r_div_den   <= wbj_pkg::DIV_DW'(r_w);
                        r_div_start <= 1'b1;
                        r_state     <= ST_P2_ADV;
                    end
                end
                ST_P2_ADV: begin
                    if (div_done) begin
                        r_tau   <= n_tau;
                        r_state <= ST_P2_ABS;
                    end
                end
                ST_P2_ABS: begin
                    r_mul_a     <= wbj_pkg::MUL_AW'(tmag);
                    r_mul_b     <= tmag;
                    r_mul_start <= 1'b1;
                    r_state     <= ST_P2_SQ;
                end
                ST_P2_SQ: begin
                    if (mul_done) begin
                        r_mul_a     <= {32'd0, mul_prod[127:32]};
                        r_mul_b     <= wbj_pkg::MUL_BW'(r_w);
                        r_mul_start <= 1'b1;
                        r_state     <= ST_P2_TML;
                    end
                end
                ST_P2_TML: begin
                    if (mul_done) begin
                        r_div_num   <= mul_prod;
                        r_div_den   <= wbj_pkg::DIV_DW'(r_yn - WT_W'(r_w));
                        r_div_start <= 1'b1;
                        r_state     <= ST_P2_TDV;
                    end
                end
                ST_P2_TDV: begin
                    if (div_done) begin
                        r_vsum  <= vs[128] ? '1 : vs[127:0];
                        r_k     <= n_k;
                        r_state <= (n_k == r_g) ? ST_VSTART : ST_P2_RD;
                    end
                end
                ST_VSTART: begin
                    r_div_num   <= r_vsum;
                    r_div_den   <= wbj_pkg::DIV_DW'(r_g);
                    r_div_start <= 1'b1;
                    r_state     <= ST_VAR;
                end
                ST_VAR: begin
                    if (div_done) begin
                        r_sv      <= div_q[63:0];
                        r_var_big <= div_q[127:62] != '0;
                        r_var_nz  <= div_q != '0;
                        r_sres    <= '0;
                        r_sbit    <= wbj_pkg::SQRT_TOP;
                        r_state   <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_sv >= trial) begin
                        r_sv   <= r_sv - trial;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_res.jack_estimate  <= jsat;
                    r_res.estimate_valid <= 1'b1;
                    r_res.std_error      <= !r_var_nz ? '0 :
                                            (r_var_big ? wbj_pkg::SE_SAT : r_sres[30:0]);
                    r_res.error_valid    <= r_var_nz;
                    r_res.kept_blocks    <= 6'(r_g);
                    r_res.overflowed     <= r_ovf;
                    r_res_valid          <= 1'b1;
                    r_state              <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_cmd.take) begin
                        r_res_valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    wbj_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    wbj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_raddr         = r_k[IDX_W-1:0];
    assign o_res           = r_res;
    assign o_sts.busy      = r_state != ST_IDLE;
    assign o_sts.res_valid = r_res_valid;

endmodule

### src/weighted_block_jackknife.sv
// Weighted block jackknife top level: intake, block store, result register
// and the full-estimate register. Uses wbj_pkg, wbj_ram and wbj_eval.
//
// Usage: block estimates arrive on the input channel (i_in_valid/o_in_ready)
// with a weight and flags. A kept block (estimate_ok set, weight nonzero) is
// written into the block RAM and counted while the store has room, else it
// sets the overflow flag; dropped blocks change nothing.
// The transfer marked last starts the final pass, which reads the RAM back
// twice through one bit-serial multiplier and one 128-step divider and ends
// in a 32-step square root; with fewer than two kept blocks the RAM is not
// read. No input is taken during the pass. The result waits in an output
// register (o_out_valid/i_out_ready); while the receiver stalls, non-final
// input transfers are still taken, and a new final pass finishes into a
// holding register until the output register is free. full_estimate is
// written through the APB port at address 0; the user must write it only
// while idle, which the block itself does not enforce. Synchronous reset
// clears the counters, flags and full_estimate; the block RAM holds no
// reset value and is only read where written.
module weighted_block_jackknife #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wbj_pkg::t_item   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output wbj_pkg::t_result o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int WT_W  = 32 + CNT_W;

    logic [CNT_W-1:0]   r_count;
    logic [WT_W-1:0]    r_wtot;
    logic               r_ovf;
    logic               r_busy;
    logic [31:0]        r_full;
    logic               r_out_valid;
    wbj_pkg::t_result   r_out;

    logic               in_fire;
    logic               keep;
    logic               store;
    logic [CNT_W-1:0]   n_count;
    logic [WT_W-1:0]    n_wtot;
    logic               n_ovf;
    wbj_pkg::t_eval_cmd cmd;
    wbj_pkg::t_eval_sts sts;
    wbj_pkg::t_result   res;
    logic [IDX_W-1:0]   raddr;
    logic [63:0]        rdata;
    logic               reg_hit;

    always_comb begin
        in_fire   = i_in_valid && o_in_ready;
        keep      = i_in.estimate_ok && (i_in.block_weight != '0);
        store     = keep && (r_count < CNT_W'(MAX_BLOCKS));
        n_count   = r_count + (store ? CNT_W'(1) : CNT_W'(0));
        n_wtot    = r_wtot + (store ? WT_W'(i_in.block_weight) : WT_W'(0));
        n_ovf     = r_ovf || (keep && !store);
        cmd.start = in_fire && i_in.last;
        cmd.take  = sts.res_valid && (!r_out_valid || i_out_ready);
        reg_hit   = paddr == wbj_pkg::ADDR_FULL_ESTIMATE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wtot      <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                if (i_in.last) begin
                    r_count <= '0;
                    r_wtot  <= '0;
                    r_ovf   <= 1'b0;
                    r_busy  <= 1'b1;
                end else begin
                    r_count <= n_count;
                    r_wtot  <= n_wtot;
                    r_ovf   <= n_ovf;
                end
            end
            if (cmd.take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
                r_busy      <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && reg_hit) begin
                r_full <= pwdata;
            end
        end
    end

    wbj_ram #(
        .WIDTH (64),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_in.block_estimate, i_in.block_weight}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    wbj_eval #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_count    (n_count),
        .i_wtotal   (n_wtot),
        .i_full_est (r_full),
        .i_overflow (n_ovf),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_res      (res)
    );

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign prdata      = reg_hit ? r_full : '0;
    assign pready      = 1'b1;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("Kept block count exceeds the store depth.");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> !sts.busy)
        else $error("Final pass started while the previous one is active.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.last) |=> (r_count == '0 && r_wtot == '0 && r_busy))
        else $error("Accumulators not cleared after the last transfer.");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_block_jackknife: random and directed block sets,
// APB writes of full_estimate between sets, and a scoreboard that predicts each result.
// Depends on wbj_pkg and the weighted_block_jackknife top level only.
module testbench;

    localparam int STORE_DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int ITEM_TARGET = 1900;

    class jackknife_board;
        logic [31:0] full_est;
        logic [31:0] est_store[STORE_DEPTH];
        logic [31:0] wgt_store[STORE_DEPTH];
        int unsigned kept;
        logic [63:0] wgt_total;
        bit overflow;
        wbj_pkg::t_result expected_q[$];
        int mismatches;
        int unexpected;

        function new();
            full_est = 0;
            kept = 0;
            wgt_total = 0;
            overflow = 0;
            mismatches = 0;
            unexpected = 0;
        endfunction

        function logic [31:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] t;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                t = res | (64'd1 << b);
                if (t * t <= v) begin
                    res = t;
                end
            end
            return res[31:0];
        endfunction

        function wbj_pkg::t_result jackknife_of_set();
            wbj_pkg::t_result r;
            longint f, m, msum, j, d, x, jack;
            logic [63:0] yn, am, ad, wmean, tmag;
            logic [127:0] acc, mag, p, a, tau, sq, term, vsum, vvar, xs;
            logic [128:0] s;
            logic [31:0] w;
            logic [31:0] root;
            bit neg;
            r = '0;
            r.kept_blocks = kept[5:0];
            r.overflowed = overflow;
            if (kept >= 2) begin
                f = longint'($signed(full_est));
                yn = wgt_total;
                acc = 0;
                msum = 0;
                for (int k = 0; k < kept; k++) begin
                    m = longint'($signed(est_store[k]));
                    am = m < 0 ? 64'(-m) : 64'(m);
                    p = 128'(am) * 128'(wgt_store[k]);
                    acc = m < 0 ? acc - p : acc + p;
                    msum += m * 65536;
                end
                neg = acc[127];
                mag = neg ? -acc : acc;
                mag = (mag << 16) / 128'(yn);
                wmean = neg ? -mag[63:0] : mag[63:0];
                j = longint'(kept) * f * 65536 - msum + longint'(wmean);
                vsum = 0;
                for (int k = 0; k < kept; k++) begin
                    m = longint'($signed(est_store[k]));
                    w = wgt_store[k];
                    d = f - m;
                    ad = d < 0 ? 64'(-d) : 64'(d);
                    a = 128'(yn) * 128'(ad);
                    a = (a << 16) / 128'(w);
                    x = m * 65536 - j;
                    xs = {{64{x[63]}}, 64'(x)};
                    tau = (d < 0 ? -a : a) + xs;
                    if (tau[127]) begin
                        tau = -tau;
                    end
                    tmag = (tau[127:63] != 0) ? wbj_pkg::TAU_SAT : tau[63:0];
                    sq = (128'(tmag) * 128'(tmag)) >> 32;
                    term = (sq * 128'(w)) / 128'(yn - 64'(w));
                    s = 129'(vsum) + 129'(term);
                    vsum = s[128] ? {128{1'b1}} : s[127:0];
                end
                vvar = vsum / 128'(kept);
                r.error_valid = (vvar != 0);
                if (vvar[127:64] != 0 || vvar[63:0] >= wbj_pkg::SQRT_TOP) begin
                    r.std_error = wbj_pkg::SE_SAT;
                end else begin
                    root = floor_sqrt(vvar[63:0]);
                    r.std_error = root[30:0];
                end
                jack = j / 65536;
                if (jack > 64'sd2147483647) jack = 64'sd2147483647;
                if (jack < -64'sd2147483648) jack = -64'sd2147483648;
                r.jack_estimate = 32'(jack);
                r.estimate_valid = 1'b1;
            end
            return r;
        endfunction

        function void note_input(wbj_pkg::t_item it);
            if (it.estimate_ok && it.block_weight != 0) begin
                if (kept < STORE_DEPTH) begin
                    est_store[kept] = it.block_estimate;
                    wgt_store[kept] = it.block_weight;
                    wgt_total += 64'(it.block_weight);
                    kept++;
                end else begin
                    overflow = 1'b1;
                end
            end
            if (it.last) begin
                expected_q = {expected_q, jackknife_of_set()};
                kept = 0;
                wgt_total = 0;
                overflow = 0;
            end
        endfunction

        function void check_result(wbj_pkg::t_result got);
            wbj_pkg::t_result exp_r;
            if (expected_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10) begin
                    $display("Unexpected result transfer: %h", got);
                end
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.jack_estimate !== exp_r.jack_estimate
                    || got.estimate_valid !== exp_r.estimate_valid
                    || got.std_error !== exp_r.std_error
                    || got.error_valid !== exp_r.error_valid
                    || got.kept_blocks !== exp_r.kept_blocks
                    || got.overflowed !== exp_r.overflowed) begin
                mismatches++;
                if (mismatches + unexpected <= 10) begin
                    $display("Mismatch: expected est %h/%b se %h/%b kept %0d ovf %b",
                             exp_r.jack_estimate, exp_r.estimate_valid, exp_r.std_error,
                             exp_r.error_valid, exp_r.kept_blocks, exp_r.overflowed);
                    $display("          actual   est %h/%b se %h/%b kept %0d ovf %b",
                             got.jack_estimate, got.estimate_valid, got.std_error,
                             got.error_valid, got.kept_blocks, got.overflowed);
                end
            end
        endfunction

        function bit pending();
            return expected_q.size() != 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    wbj_pkg::t_item i_in;
    logic o_out_valid;
    logic i_out_ready;
    wbj_pkg::t_result o_out;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    jackknife_board board;
    int send_idle;
    int recv_idle;
    int stall_left;
    int quiet_cycles;
    int items_sent;

    weighted_block_jackknife dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (i_in_valid && o_in_ready) begin
                board.note_input(i_in);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_item(wbj_pkg::t_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = it;
        items_sent++;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_full_estimate(logic [31:0] value);
        i_in_valid = 1'b0;
        while (board.pending()) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = wbj_pkg::ADDR_FULL_ESTIMATE;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        board.full_est = value;
    endtask

    task automatic send_block(logic [31:0] est, bit ok, logic [31:0] wgt, bit fin);
        wbj_pkg::t_item it;
        it.block_estimate = est;
        it.estimate_ok = ok;
        it.block_weight = wgt;
        it.last = fin;
        send_item(it);
    endtask

    task automatic send_random_set();
        int n, pick;
        logic [31:0] est, wgt;
        pick = $urandom_range(0, 99);
        if (pick < 3) n = $urandom_range(33, 36);
        else if (pick < 10) n = 1;
        else n = $urandom_range(2, 7);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) est = board.full_est + $urandom_range(0, 2097152) - 32'd1048576;
            else if (pick < 80) est = $urandom;
            else est = $urandom_range(0, 131071) - 32'd65536;
            pick = $urandom_range(0, 99);
            if (pick < 50) wgt = $urandom_range(1, 16);
            else if (pick < 75) wgt = $urandom_range(1, 65535);
            else wgt = $urandom;
            send_block(est, $urandom_range(0, 99) < 92, wgt, i == n - 1);
        end
    endtask

    initial begin
        int sets;
        logic [31:0] f_pick;
        board = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 38;
        recv_idle = 50;
        stall_left = 0;
        quiet_cycles = 0;
        items_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_full_estimate(32'h0001_0000);
        send_block(32'h0, 1'b0, 32'h5, 1'b1);
        send_block(32'h0002_0000, 1'b1, 32'h1, 1'b1);
        send_block(32'h0001_0000, 1'b1, 32'h3, 1'b0);
        send_block(32'h0001_0000, 1'b1, 32'h3, 1'b1);
        send_block(32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_block(32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_block(32'h1234_5678, 1'b1, 32'h0, 1'b0);
        send_block(32'h0, 1'b0, 32'h0, 1'b1);
        write_full_estimate(32'h7FFF_FFFF);
        send_block(32'h8000_0000, 1'b1, 32'h1, 1'b0);
        send_block(32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1);
        write_full_estimate(32'h8000_0000);
        send_block(32'h7FFF_FFFF, 1'b1, 32'h2, 1'b0);
        send_block(32'h7FFF_FFFF, 1'b1, 32'h1, 1'b0);
        send_block(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1);

        sets = 0;
        while (items_sent < ITEM_TARGET) begin
            if (sets % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0: f_pick = 32'h7FFF_FFFF;
                    1: f_pick = 32'h8000_0000;
                    2: f_pick = $urandom;
                    default: f_pick = $urandom_range(0, 1048575) - 32'd524288;
                endcase
                write_full_estimate(f_pick);
            end
            if (items_sent > ITEM_TARGET / 3 && send_idle == 38) begin
                send_idle = 50;
                recv_idle = 38;
                stall_left = 12000;
            end else if (items_sent > 2 * ITEM_TARGET / 3 && send_idle == 50) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_random_set();
            sets++;
        end
        i_in_valid = 1'b0;
        while (board.pending()) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (board.mismatches == 0 && board.unexpected == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
